// ----- design/rdsd_pkg.sv -----
// Shared types, constants and the control program of the reciprocal digit-search divider.
`default_nettype none

package rdsd_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int MAX_STEPS_DEF  = 256;
    localparam int UPC_W          = 4;

    typedef enum logic [1:0] {
        ST_EXACT      = 2'd0,
        ST_NEAR       = 2'd1,
        ST_DIV_ZERO   = 2'd2,
        ST_STEP_LIMIT = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0] numerator;
        logic [31:0] divisor;
    } t_in_item;

    typedef struct packed {
        logic [31:0] reciprocal;
        logic [63:0] quotient;
        logic [8:0]  steps_used;
        logic [4:0]  norm_shift;
        t_status     status;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ZERO,
        OP_NORM,
        OP_SEED,
        OP_BLEN,
        OP_MUL_RD,
        OP_CHECK,
        OP_MUL_TF,
        OP_DIV31,
        OP_SUB,
        OP_ADD,
        OP_LIMIT,
        OP_MUL_RN,
        OP_OUT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_D_NZ,
        C_EVEN,
        C_T_NZ,
        C_STOP,
        C_NOT_OVER,
        C_X_GE32,
        C_STEPS_LT,
        C_OUT_BUSY
    } t_cond;

    typedef logic [UPC_W-1:0] t_upc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  jmp;
    } t_cw;

    typedef struct packed {
        logic d_nz;
        logic even;
        logic t_nz;
        logic stop;
        logic not_over;
        logic x_ge32;
        logic steps_lt;
    } t_flags;

    typedef struct packed {
        t_op  op;
        logic idle;
    } t_ctl;

    localparam t_upc S_WAIT   = 4'd0;
    localparam t_upc S_ZCHK   = 4'd1;
    localparam t_upc S_ZERO   = 4'd2;
    localparam t_upc S_NORM   = 4'd3;
    localparam t_upc S_SEED   = 4'd4;
    localparam t_upc S_BLEN   = 4'd5;
    localparam t_upc S_MUL_RD = 4'd6;
    localparam t_upc S_CHECK  = 4'd7;
    localparam t_upc S_BRANCH = 4'd8;
    localparam t_upc S_MUL_TF = 4'd9;
    localparam t_upc S_DIV31  = 4'd10;
    localparam t_upc S_SUB    = 4'd11;
    localparam t_upc S_ADD    = 4'd12;
    localparam t_upc S_LOOP   = 4'd13;
    localparam t_upc S_FINAL  = 4'd14;
    localparam t_upc S_OUT    = 4'd15;

    // The program fills all sixteen steps, so falling through the last step returns to the wait step.
    function automatic t_cw rdsd_ucode(input t_upc a);
        t_cw w;
        unique case (a)
            S_WAIT:   w = '{op: OP_LOAD,   cond: C_NO_IN,    jmp: S_WAIT};
            S_ZCHK:   w = '{op: OP_NOP,    cond: C_D_NZ,     jmp: S_NORM};
            S_ZERO:   w = '{op: OP_ZERO,   cond: C_ALWAYS,   jmp: S_OUT};
            S_NORM:   w = '{op: OP_NORM,   cond: C_EVEN,     jmp: S_NORM};
            S_SEED:   w = '{op: OP_SEED,   cond: C_NEVER,    jmp: S_BLEN};
            S_BLEN:   w = '{op: OP_BLEN,   cond: C_T_NZ,     jmp: S_BLEN};
            S_MUL_RD: w = '{op: OP_MUL_RD, cond: C_NEVER,    jmp: S_CHECK};
            S_CHECK:  w = '{op: OP_CHECK,  cond: C_STOP,     jmp: S_FINAL};
            S_BRANCH: w = '{op: OP_NOP,    cond: C_NOT_OVER, jmp: S_ADD};
            S_MUL_TF: w = '{op: OP_MUL_TF, cond: C_NEVER,    jmp: S_DIV31};
            S_DIV31:  w = '{op: OP_DIV31,  cond: C_X_GE32,   jmp: S_DIV31};
            S_SUB:    w = '{op: OP_SUB,    cond: C_ALWAYS,   jmp: S_LOOP};
            S_ADD:    w = '{op: OP_ADD,    cond: C_NEVER,    jmp: S_LOOP};
            S_LOOP:   w = '{op: OP_LIMIT,  cond: C_STEPS_LT, jmp: S_MUL_RD};
            S_FINAL:  w = '{op: OP_MUL_RN, cond: C_NEVER,    jmp: S_OUT};
            S_OUT:    w = '{op: OP_OUT,    cond: C_OUT_BUSY, jmp: S_OUT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- design/reciprocal_digit_search_divider.sv -----
// Top level of the reciprocal digit-search divider with its output register.
// Each transaction is loaded, its common trailing zeros are shifted out, the bit length of the
// reduced divisor sets the seed, and loop passes refine the reciprocal by an add or by a subtract
// with reducing rounds of the divide-by-31 unit; a zero divisor goes straight to the output.
// One transaction is worked at a time; the next is taken in the cycle after the result is stored.
// Synchronous active-low reset returns the sequencer to its wait step and empties the output.
`default_nettype none

module reciprocal_digit_search_divider import rdsd_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int MAX_STEPS  = MAX_STEPS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out
);

    t_ctl      ctl;
    t_flags    flags;
    t_out_item result;
    logic      out_busy;
    logic      out_load;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out;

    rdsd_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flags    (flags),
        .i_in_valid (i_in_valid),
        .i_out_busy (out_busy),
        .o_ctl      (ctl)
    );

    rdsd_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .MAX_STEPS  (MAX_STEPS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_op     (ctl.op),
        .i_in     (i_in),
        .o_flags  (flags),
        .o_result (result)
    );

    always_comb begin
        out_busy = r_out_valid && i_out_stall;
        out_load = (ctl.op == OP_OUT) && !out_busy;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= result;
        end
    end

    assign o_in_stall  = !ctl.idle;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- design/rdsd_useq.sv -----
// Microcode sequencer: step counter, control program lookup and conditional jumps.
`default_nettype none

module rdsd_useq import rdsd_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_flags i_flags,
    input  wire logic   i_in_valid,
    input  wire logic   i_out_busy,
    output t_ctl        o_ctl
);

    t_upc r_upc;
    t_upc n_upc;
    t_cw  cw;
    logic take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

    always_comb begin
        cw = rdsd_ucode(r_upc);
        unique case (cw.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_IN:    take = !i_in_valid;
            C_D_NZ:     take = i_flags.d_nz;
            C_EVEN:     take = i_flags.even;
            C_T_NZ:     take = i_flags.t_nz;
            C_STOP:     take = i_flags.stop;
            C_NOT_OVER: take = i_flags.not_over;
            C_X_GE32:   take = i_flags.x_ge32;
            C_STEPS_LT: take = i_flags.steps_lt;
            C_OUT_BUSY: take = i_out_busy;
            default:    take = 1'b0;
        endcase
        n_upc      = take ? cw.jmp : r_upc + UPC_W'(1);
        o_ctl.op   = cw.op;
        o_ctl.idle = (r_upc == S_WAIT);
    end

endmodule

`default_nettype wire

// ----- design/rdsd_datapath.sv -----
// Datapath of the divider: operand registers, shared multiplier and refinement arithmetic.
`default_nettype none

module rdsd_datapath import rdsd_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int MAX_STEPS  = MAX_STEPS_DEF
) (
    input  wire logic     i_clk,
    input  wire t_op      i_op,
    input  wire t_in_item i_in,
    output t_flags        o_flags,
    output t_out_item     o_result
);

    localparam int DW        = DATA_WIDTH;
    localparam int DIGIT_CAP = DW / 4;
    localparam int IDX_W     = $clog2(DIGIT_CAP + 1);
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    function automatic logic [DW+3:0] add_term(input logic [3:0] dg, input logic [DW-1:0] t);
        logic [DW+3:0] r;
        logic [DW+3:0] s;
        r = {4'b0, t};
        unique case (dg)
            4'd0:  s = r;
            4'd1:  s = (r << 3) + (r << 2) + (r << 1);
            4'd2:  s = (r << 2) + (r << 1) + (r >> 1);
            4'd3:  s = r << 2;
            4'd4:  s = (r << 1) + (r >> 1) + (r >> 2);
            4'd5:  s = r << 1;
            4'd6:  s = r + (r >> 1);
            4'd7:  s = r + (r >> 2) + (r >> 5);
            4'd8:  s = r;
            4'd9:  s = (r >> 1) + (r >> 3) + (r >> 5) + (r >> 7);
            4'd10: s = r >> 1;
            4'd11: s = (r >> 2) + (r >> 4) + (r >> 5) + (r >> 6);
            4'd12: s = r >> 2;
            4'd13: s = (r >> 3) + (r >> 6) + (r >> 7) + (r >> 8);
            4'd14: s = (r >> 4) + (r >> 7) + (r >> 10);
            4'd15: s = '0;
        endcase
        return s;
    endfunction

    logic [DW-1:0]     r_n, n_n;
    logic [DW-1:0]     r_d, n_d;
    logic [DW-1:0]     r_t, n_t;
    logic [DW:0]       r_recip, n_recip;
    logic [2*DW-1:0]   r_prod, n_prod;
    logic [DW+4:0]     r_x, n_x;
    logic [DW:0]       r_q, n_q;
    logic [3:0]        r_digit, n_digit;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic [4:0]        r_shift, n_shift;
    t_status           r_status, n_status;

    logic [DW-1:0]     mul_a;
    logic [DW-1:0]     mul_b;
    logic [2*DW-1:0]   mul_p;
    logic [DW-1:0]     low;
    logic [DW-1:0]     high;
    logic              exact;
    logic              near;
    logic [3:0]        digit_sel;
    logic [DW-1:0]     t_sel;
    logic [DW+3:0]     add_d;
    logic [DW+4:0]     add_sum;
    logic [DW-1:0]     x_hi;
    logic [DW:0]       sub_d;

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_d      <= n_d;
        r_t      <= n_t;
        r_recip  <= n_recip;
        r_prod   <= n_prod;
        r_x      <= n_x;
        r_q      <= n_q;
        r_digit  <= n_digit;
        r_idx    <= n_idx;
        r_steps  <= n_steps;
        r_shift  <= n_shift;
        r_status <= n_status;
    end

    always_comb begin
        mul_a = (i_op == OP_MUL_TF) ? r_t : r_recip[DW-1:0];
        if (i_op == OP_MUL_TF) begin
            mul_b = DW'({r_digit, 1'b1});
        end else if (i_op == OP_MUL_RN) begin
            mul_b = r_n;
        end else begin
            mul_b = r_d;
        end
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        low   = r_prod[DW-1:0];
        high  = r_prod[2*DW-1:DW];
        exact = (high == DW'(1)) && (low == '0);
        near  = (low < r_d) || (~low < r_d);

        digit_sel = '0;
        t_sel     = '0;
        for (int k = 1; k <= DIGIT_CAP; k++) begin
            if (r_idx == IDX_W'(k)) begin
                digit_sel = r_prod[DW-4*k +: 4];
                t_sel     = r_recip[DW-1:0] >> (4 * (k - 1));
            end
        end

        add_d = add_term(r_digit, r_t);
        if (add_d == '0) begin
            add_d = (DW+4)'(1);
        end
        add_sum = {4'b0, r_recip} + {1'b0, add_d};

        x_hi  = r_x[DW+4:5];
        sub_d = r_q + {{DW{1'b0}}, (r_x == (DW+5)'(31))};
        if (sub_d == '0) begin
            sub_d = (DW+1)'(1);
        end
    end

    always_comb begin
        n_n      = r_n;
        n_d      = r_d;
        n_t      = r_t;
        n_recip  = r_recip;
        n_prod   = r_prod;
        n_x      = r_x;
        n_q      = r_q;
        n_digit  = r_digit;
        n_idx    = r_idx;
        n_steps  = r_steps;
        n_shift  = r_shift;
        n_status = r_status;

        unique case (i_op)
            OP_LOAD: begin
                n_n     = i_in.numerator[DW-1:0];
                n_d     = i_in.divisor[DW-1:0];
                n_shift = '0;
            end
            OP_ZERO: begin
                n_recip  = '0;
                n_prod   = '0;
                n_steps  = '0;
                n_shift  = '0;
                n_status = ST_DIV_ZERO;
            end
            OP_NORM: begin
                if (!(r_n[0] || r_d[0])) begin
                    n_n     = r_n >> 1;
                    n_d     = r_d >> 1;
                    n_shift = r_shift + 5'd1;
                end
            end
            OP_SEED: begin
                n_t     = r_d;
                n_recip = {1'b1, {DW{1'b0}}};
                n_steps = '0;
                n_idx   = IDX_W'(1);
            end
            OP_BLEN: begin
                if (r_t != '0) begin
                    n_t     = r_t >> 1;
                    n_recip = r_recip >> 1;
                end
            end
            OP_MUL_RD: begin
                n_prod  = mul_p;
                n_steps = r_steps + STEP_W'(1);
            end
            OP_CHECK: begin
                n_digit = digit_sel;
                n_t     = t_sel;
                if (exact) begin
                    n_status = ST_EXACT;
                end else if (near) begin
                    n_status = ST_NEAR;
                end
            end
            OP_MUL_TF: begin
                n_x = mul_p[DW+4:0];
                n_q = '0;
            end
            OP_DIV31: begin
                if (x_hi != '0) begin
                    n_q = r_q + {1'b0, x_hi};
                    n_x = {5'b0, x_hi} + {{DW{1'b0}}, r_x[4:0]};
                end
            end
            OP_SUB: begin
                n_recip = (sub_d <= r_recip) ? r_recip - sub_d : '0;
            end
            OP_ADD: begin
                if ((r_digit == 4'hf) && (r_idx < IDX_W'(DIGIT_CAP))) begin
                    n_idx = r_idx + IDX_W'(1);
                end
                if (add_sum > (DW+5)'({DW{1'b1}})) begin
                    n_recip = {1'b0, {DW{1'b1}}};
                end else begin
                    n_recip = add_sum[DW:0];
                end
            end
            OP_LIMIT: begin
                n_status = ST_STEP_LIMIT;
            end
            OP_MUL_RN: begin
                n_prod = mul_p;
            end
            OP_NOP, OP_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_flags.d_nz     = (r_d != '0);
        o_flags.even     = !(r_n[0] || r_d[0]);
        o_flags.t_nz     = (r_t != '0);
        o_flags.stop     = exact || near;
        o_flags.not_over = (high == '0);
        o_flags.x_ge32   = (x_hi != '0);
        o_flags.steps_lt = (r_steps < STEP_W'(MAX_STEPS));

        o_result.reciprocal = 32'(r_recip[DW-1:0]);
        o_result.quotient   = 64'(r_prod);
        o_result.steps_used = 9'(r_steps);
        o_result.norm_shift = r_shift;
        o_result.status     = r_status;
    end

endmodule

`default_nettype wire

// ----- design/rdsd_checker.sv -----
// Port-level assertions for the divider and the bind that attaches them.
`default_nettype none

module rdsd_checker import rdsd_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("output transaction changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transaction");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_DIV_ZERO) |->
        (o_out.reciprocal == '0) && (o_out.quotient == '0) &&
        (o_out.steps_used == '0) && (o_out.norm_shift == '0))
        else $error("divide-by-zero result carries nonzero fields");

    a_steps_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ST_DIV_ZERO) |->
        (o_out.steps_used != '0) && (o_out.steps_used <= 9'(MAX_STEPS)))
        else $error("step count out of range");

    a_limit_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_STEP_LIMIT) |->
        o_out.steps_used == 9'(MAX_STEPS))
        else $error("step limit reported before the last step");

endmodule

bind reciprocal_digit_search_divider rdsd_checker #(
    .MAX_STEPS (MAX_STEPS)
) u_rdsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the reciprocal digit-search divider.
`timescale 1ns / 1ps

module tb;
    import rdsd_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int CALM_TAIL    = 150;
    localparam int DRAIN_CYCLES = 64;
    localparam int STALL_LIMIT  = 200000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    t_in_item  operand_backlog[$];
    t_out_item divisions_due[$];
    int unsigned in_gap = 0;
    int unsigned out_gap = 0;
    int unsigned quiet_cycles = 0;
    int unsigned errors = 0;

    reciprocal_digit_search_divider i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_out_item predict_division(input t_in_item op);
        t_out_item   res;
        logic [63:0] num, den, recip, prod, delta, tv;
        logic [31:0] lo, lo_n;
        logic [3:0]  nib;
        int unsigned shift, blen, idx, steps;
        t_status     st;
        res = '0;
        num = {32'd0, op.numerator};
        den = {32'd0, op.divisor};
        if (den == 64'd0) begin
            res.status = ST_DIV_ZERO;
            return res;
        end
        shift = 0;
        while (((num | den) & 64'd1) == 64'd0) begin
            num = num >> 1;
            den = den >> 1;
            shift++;
        end
        blen = 0;
        for (tv = den; tv != 64'd0; tv = tv >> 1)
            blen++;
        recip = 64'd1 << (32 - blen);
        idx = 1;
        steps = 0;
        st = ST_STEP_LIMIT;
        while (steps < 256) begin
            steps++;
            prod = recip * den;
            lo = prod[31:0];
            lo_n = ~lo;
            if (prod == 64'h1_0000_0000) begin
                st = ST_EXACT;
                break;
            end
            if ({32'd0, lo} < den || {32'd0, lo_n} < den) begin
                st = ST_NEAR;
                break;
            end
            nib = 4'(prod >> (32 - 4 * idx));
            tv = recip >> (4 * (idx - 1));
            if (prod[63:32] != 32'd0) begin
                delta = (tv * (64'd1 + 64'd2 * nib)) / 64'd31;
                if (delta == 64'd0)
                    delta = 64'd1;
                recip = (delta <= recip) ? recip - delta : 64'd0;
            end else begin
                case (nib)
                    4'd1:  delta = (tv << 3) + (tv << 2) + (tv << 1);
                    4'd2:  delta = (tv << 2) + (tv << 1) + (tv >> 1);
                    4'd3:  delta = tv << 2;
                    4'd4:  delta = (tv << 1) + (tv >> 1) + (tv >> 2);
                    4'd5:  delta = tv << 1;
                    4'd6:  delta = tv + (tv >> 1);
                    4'd7:  delta = tv + (tv >> 2) + (tv >> 5);
                    4'd9:  delta = (tv >> 1) + (tv >> 3) + (tv >> 5) + (tv >> 7);
                    4'd10: delta = tv >> 1;
                    4'd11: delta = (tv >> 2) + (tv >> 4) + (tv >> 5) + (tv >> 6);
                    4'd12: delta = tv >> 2;
                    4'd13: delta = (tv >> 3) + (tv >> 6) + (tv >> 7) + (tv >> 8);
                    4'd14: delta = (tv >> 4) + (tv >> 7) + (tv >> 10);
                    4'd15: delta = 64'd0;
                    default: delta = tv;
                endcase
                if (nib == 4'd15 && idx < 8)
                    idx++;
                if (delta == 64'd0)
                    delta = 64'd1;
                recip = recip + delta;
                if (recip > 64'hffff_ffff)
                    recip = 64'hffff_ffff;
            end
        end
        res.reciprocal = recip[31:0];
        res.quotient = recip * num;
        res.steps_used = steps[8:0];
        res.norm_shift = shift[4:0];
        res.status = st;
        return res;
    endfunction

    task automatic flag_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    task automatic add_operands(input logic [31:0] n, input logic [31:0] d);
        t_in_item op;
        op.numerator = n;
        op.divisor = d;
        operand_backlog.push_back(op);
    endtask

    // Source side: the next transaction is presented only once the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                divisions_due.push_back(predict_division(in_item));
            if (!in_valid || !in_stall) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (operand_backlog.size() > CALM_TAIL &&
                             $urandom_range(0, 15) == 0) begin
                    in_gap <= $urandom_range(0, 12);
                    in_valid <= 1'b0;
                end else if (operand_backlog.size() > 0) begin
                    in_item <= operand_backlog.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Sink side: checks every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (divisions_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, out_item);
                end else begin
                    want = divisions_due.pop_front();
                    if (out_item.reciprocal !== want.reciprocal)
                        flag_mismatch("reciprocal", want.reciprocal, out_item.reciprocal);
                    if (out_item.quotient !== want.quotient)
                        flag_mismatch("quotient", want.quotient, out_item.quotient);
                    if (out_item.steps_used !== want.steps_used)
                        flag_mismatch("steps_used", want.steps_used, out_item.steps_used);
                    if (out_item.norm_shift !== want.norm_shift)
                        flag_mismatch("norm_shift", want.norm_shift, out_item.norm_shift);
                    if (out_item.status !== want.status)
                        flag_mismatch("status", want.status, out_item.status);
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end else if (operand_backlog.size() > CALM_TAIL &&
                         $urandom_range(0, 15) == 0) begin
                out_gap <= $urandom_range(0, 12);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [31:0] n, d;
        int unsigned k;

        add_operands(32'h0000_0064, 32'h0000_0000);
        add_operands(32'hffff_ffff, 32'h0000_0000);
        add_operands(32'h0000_0000, 32'h0000_0000);
        add_operands(32'h0000_0000, 32'h0000_0001);
        add_operands(32'hffff_ffff, 32'h0000_0001);
        add_operands(32'hffff_ffff, 32'hffff_ffff);
        add_operands(32'h0000_0000, 32'h8000_0000);
        add_operands(32'h8000_0000, 32'h8000_0000);
        add_operands(32'h1234_5678, 32'h0000_0003);
        add_operands(32'hffff_ffff, 32'h0000_0007);
        add_operands(32'h0000_0001, 32'hffff_fffe);
        add_operands(32'haaaa_aaaa, 32'h5555_5555);
        add_operands(32'h5555_5555, 32'haaaa_aaaa);
        add_operands(32'hffff_0000, 32'h0001_0000);
        add_operands(32'h0000_0007, 32'h0000_001f);
        add_operands(32'h0000_1000, 32'h0000_0010);
        add_operands(32'hdead_beef, 32'h0000_ffff);
        add_operands(32'hffff_ffff, 32'h7fff_ffff);
        add_operands(32'h0000_0001, 32'h8000_0001);
        add_operands(32'hffff_fffe, 32'hffff_fffe);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            n = $urandom;
            d = $urandom;
            case ($urandom_range(0, 9))
                0, 1, 2: ;
                3, 4:    d = $urandom_range(1, 255);
                5: begin
                    k = $urandom_range(0, 31);
                    d = (d | 32'd1) << k;
                    n = n << k;
                end
                6: begin
                    k = $urandom_range(0, 31);
                    d = 32'($urandom_range(1, 15)) << k;
                end
                7:       d = d | 32'hf000_0000;
                8: begin
                    n = $urandom_range(0, 1) ? 32'hffff_ffff : 32'd0;
                    d = d >> $urandom_range(0, 31);
                end
                default: d = ($urandom_range(0, 3) == 0) ? 32'd0 : d >> $urandom_range(0, 31);
            endcase
            add_operands(n, d);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (operand_backlog.size() != 0 || in_valid || divisions_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && divisions_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- reciprocal_digit_search_divider.f -----
design/rdsd_pkg.sv
design/rdsd_useq.sv
design/rdsd_datapath.sv
design/reciprocal_digit_search_divider.sv
design/rdsd_checker.sv
tb/sv/tb.sv
